[rtl/mod_matrix_power_2x2_core_defines.svh]
// ----------------------------------------------------------------------------
// mod_matrix_power_2x2_core_defines
// assertion macros shared by the matrix power core
// ----------------------------------------------------------------------------
`ifndef MOD_MATRIX_POWER_2X2_CORE_DEFINES_SVH
`define MOD_MATRIX_POWER_2X2_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MMP_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(prop)) else $error("mmp assertion failed");
`define MMP_ASSERT_IMPL(lbl, ante, cons) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |-> (cons)) else $error("mmp implication failed");
`else
`define MMP_ASSERT(lbl, prop)
`define MMP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

[rtl/mmp_pkg.sv]
// ----------------------------------------------------------------------------
// mmp_pkg
// types and constants of the modular 2x2 matrix power core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mmp_pkg;
	localparam int WORD_BITS = 32;
	localparam int POW_BITS = 63;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int SUM_BITS = PROD_BITS + 1;
	localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(32'd1000000007);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [31:0] entry_00;
		logic [31:0] entry_01;
		logic [31:0] entry_10;
		logic [31:0] entry_11;
		logic [62:0] power;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] out_00;
		logic [31:0] out_01;
		logic [31:0] out_10;
		logic [31:0] out_11;
	} out_beat_t;

	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
		word_t t;
		word_t m;
	} mr_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t result;
	} mr_rsp_t;
endpackage

[rtl/mmp_mulred.sv]
// ----------------------------------------------------------------------------
// mmp_mulred
// shared multiply-accumulate unit with bit-serial modular reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmp_mulred (
	input  logic            clk,
	input  logic            arst_n,
	input  mmp_pkg::mr_req_t req,
	output mmp_pkg::mr_rsp_t rsp
);
	import mmp_pkg::*;

	localparam int CNT_BITS = $clog2(SUM_BITS);

	typedef enum logic [4:0] {
		U_IDLE = 5'b00001,
		U_MUL  = 5'b00010,
		U_ADD  = 5'b00100,
		U_DIV  = 5'b01000,
		U_DONE = 5'b10000
	} ustate_t;

	ustate_t state_q;
	word_t a_q, b_q, t_q, m_q, rem_q;
	logic [PROD_BITS-1:0] p_q;
	logic [SUM_BITS-1:0] s_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [WORD_BITS:0] sh;
	word_t rem_next;

	// one restoring step: remainder stays below the modulus
	always_comb begin
		sh = {rem_q, s_q[SUM_BITS-1]};
		if (sh >= {1'b0, m_q}) begin
			rem_next = WORD_BITS'(sh - {1'b0, m_q});
		end else begin
			rem_next = sh[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: if (req.start) state_q <= U_MUL;
				U_MUL:  state_q <= U_ADD;
				U_ADD: begin
					state_q <= (m_q == '0) ? U_DONE : U_DIV;
					cnt_q   <= CNT_BITS'(SUM_BITS - 1);
				end
				U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= U_DONE;
				end
				U_DONE: state_q <= U_IDLE;
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				a_q <= req.a;
				b_q <= req.b;
				t_q <= req.t;
				m_q <= req.m;
			end
			U_MUL: p_q <= a_q * b_q;
			U_ADD: begin
				s_q   <= {1'b0, p_q} + {{(SUM_BITS-WORD_BITS){1'b0}}, t_q};
				// zero modulus means reduction by 2^WORD_BITS
				rem_q <= (m_q == '0) ? (p_q[WORD_BITS-1:0] + t_q) : '0;
			end
			U_DIV: begin
				rem_q <= rem_next;
				s_q   <= {s_q[SUM_BITS-2:0], 1'b0};
			end
			U_DONE: ;
			default: ;
		endcase
	end

	assign rsp.busy   = (state_q != U_IDLE);
	assign rsp.done   = (state_q == U_DONE);
	assign rsp.result = rem_q;
endmodule

[rtl/mod_matrix_power_2x2_core.sv]
// ----------------------------------------------------------------------------
// mod_matrix_power_2x2_core
// modular 2x2 matrix power by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_ready  | in_data (entries, power)
// out     | source    | out_valid/out_ready| out_data (result entries)
// cfg     | sink      | cfg_we             | cfg_wdata (modulus)
//
// each matrix product is 8 multiply-accumulate terms on one shared unit;
// a term runs the 65-step serial reduction, which a zero modulus skips
// a nonzero power runs one squaring product per bit and one more product per set bit,
// counting bits up to the top set bit of power; a zero power goes straight to the result
// reset returns the modulus to 1000000007 and drops any beat in flight
// a result waiting on out_ready does not block the next input beat; the
// next one is held only at its end until the output register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mod_matrix_power_2x2_core_defines.svh"
module mod_matrix_power_2x2_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mmp_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mmp_pkg::out_beat_t out_data,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);
	import mmp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ISSUE  = 5'b00010,
		S_WAIT   = 5'b00100,
		S_COMMIT = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	state_t state_q;
	word_t modulus_q;
	word_t [1:0][1:0] base_q, acc_q, tmp_q;
	logic [POW_BITS-1:0] e_q;
	logic [POW_BITS-1:0] e_shift;
	logic mul_q;      // current product is acc * base, else base * base
	logic [2:0] cnt_q; // {row, col, term}
	word_t t_q;
	logic out_valid_q;
	out_beat_t out_q;
	logic fin_fire;   // result moves into the output register

	mr_req_t req;
	mr_rsp_t rsp;

	logic ri, cj, tk;
	assign ri = cnt_q[2];
	assign cj = cnt_q[1];
	assign tk = cnt_q[0];
	assign e_shift = e_q >> 1;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// operand select for the current term
	always_comb begin
		req.start = (state_q == S_ISSUE);
		req.a     = mul_q ? acc_q[ri][tk] : base_q[ri][tk];
		req.b     = base_q[tk][cj];
		req.t     = tk ? t_q : '0;
		req.m     = modulus_q;
	end

	mmp_mulred u_mulred (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// modulus register, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata[WORD_BITS-1:0];
		end
	end

	// output beat valid: set on a finished item, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					cnt_q   <= '0;
					state_q <= (in_data.power == '0) ? S_FIN : S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: if (rsp.done) begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == 3'd7) ? S_COMMIT : S_ISSUE;
				end
				S_COMMIT: begin
					if (!mul_q && e_shift == '0) state_q <= S_FIN;
					else state_q <= S_ISSUE;
				end
				S_FIN: if (fin_fire) begin
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// matrix registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				base_q[0][0] <= in_data.entry_00[WORD_BITS-1:0];
				base_q[0][1] <= in_data.entry_01[WORD_BITS-1:0];
				base_q[1][0] <= in_data.entry_10[WORD_BITS-1:0];
				base_q[1][1] <= in_data.entry_11[WORD_BITS-1:0];
				acc_q[0][0]  <= WORD_BITS'(1);
				acc_q[0][1]  <= '0;
				acc_q[1][0]  <= '0;
				acc_q[1][1]  <= WORD_BITS'(1);
				e_q          <= in_data.power;
				mul_q        <= in_data.power[0];
			end
			S_ISSUE: ;
			S_WAIT: if (rsp.done) begin
				t_q <= rsp.result;
				if (tk) tmp_q[ri][cj] <= rsp.result;
			end
			S_COMMIT: begin
				if (mul_q) begin
					acc_q <= tmp_q;
					mul_q <= 1'b0;
				end else begin
					base_q <= tmp_q;
					e_q    <= e_shift;
					mul_q  <= e_shift[0];
				end
			end
			S_FIN: if (fin_fire) begin
				out_q.out_00 <= 32'(acc_q[0][0]);
				out_q.out_01 <= 32'(acc_q[0][1]);
				out_q.out_10 <= 32'(acc_q[1][0]);
				out_q.out_11 <= 32'(acc_q[1][1]);
			end
			default: ;
		endcase
	end

	// shared unit is free whenever a new beat can be taken
	`MMP_ASSERT_IMPL(a_idle_unit_free, state_q == S_IDLE, !rsp.busy)
	// every reduced term is below a nonzero modulus
	`MMP_ASSERT_IMPL(a_term_reduced, state_q == S_WAIT && rsp.done && modulus_q != '0,
		rsp.result < modulus_q)
	// a zero power goes straight to the result
	`MMP_ASSERT_IMPL(a_zero_power, in_valid && in_ready && in_data.power == '0,
		##1 state_q == S_FIN)
endmodule

[verif/tb_mod_matrix_power_2x2_core.sv]
// ----------------------------------------------------------------------------
// tb_mod_matrix_power_2x2_core
// self-checking bench for the modular 2x2 matrix power core
// ----------------------------------------------------------------------------
// every accepted input beat is run through a square-and-multiply predictor
// kept in the bench, and each output beat is compared entry by entry with the
// oldest predicted matrix. the modulus is rewritten between phases while the
// core is idle; phases vary sender gaps and receiver stalls, and one long
// receiver hold-off makes the core back up its input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_mod_matrix_power_2x2_core;
	import mmp_pkg::*;

	typedef longint unsigned mat_t [4];

	// predicted results of accepted matrices, oldest first
	class power_scoreboard;
		longint unsigned modulus;
		out_beat_t       pending_powers[$];
		int              errors;
		int              checked;

		function new();
			modulus = 64'(MODULUS_RESET);
			errors = 0;
			checked = 0;
		endfunction

		function longint unsigned reduce(longint unsigned x);
			if (modulus == 0) return x & 64'hffff_ffff;
			return x % modulus;
		endfunction

		// each entry accumulated term by term, reduced after every term
		function mat_t mat_mul(mat_t x, mat_t y);
			mat_t r;
			longint unsigned t;
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					t = 0;
					t = reduce(t + x[i*2] * y[j]);
					t = reduce(t + x[i*2+1] * y[2+j]);
					r[i*2+j] = t;
				end
			end
			return r;
		endfunction

		function void note_input(in_beat_t b);
			mat_t       base;
			mat_t       acc;
			logic [62:0] e;
			out_beat_t  o;
			base = '{b.entry_00, b.entry_01, b.entry_10, b.entry_11};
			acc = '{1, 0, 0, 1};
			e = b.power;
			while (e != 0) begin
				if (e[0]) acc = mat_mul(acc, base);
				base = mat_mul(base, base);
				e = e >> 1;
			end
			o.out_00 = acc[0][31:0];
			o.out_01 = acc[1][31:0];
			o.out_10 = acc[2][31:0];
			o.out_11 = acc[3][31:0];
			pending_powers.push_back(o);
		endfunction

		function void check(out_beat_t got);
			out_beat_t want;
			if (pending_powers.size() == 0) begin
				$error("unexpected result beat %h", got);
				errors++;
				return;
			end
			want = pending_powers.pop_front();
			checked++;
			if (got.out_00 !== want.out_00) begin
				$error("out_00 expected %h actual %h", want.out_00, got.out_00);
				errors++;
			end
			if (got.out_01 !== want.out_01) begin
				$error("out_01 expected %h actual %h", want.out_01, got.out_01);
				errors++;
			end
			if (got.out_10 !== want.out_10) begin
				$error("out_10 expected %h actual %h", want.out_10, got.out_10);
				errors++;
			end
			if (got.out_11 !== want.out_11) begin
				$error("out_11 expected %h actual %h", want.out_11, got.out_11);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_beat_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_beat_t   out_data;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	power_scoreboard sb = new();

	// idling percentages for the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// long hold-off request, taken over by the receiver process
	int hold_req = 0;
	int hold_left = 0;
	int sent = 0;
	int phases = 0;

	mod_matrix_power_2x2_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result beats go straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check(out_data);
	end

	// offer one beat; valid stays high across back-to-back beats
	task automatic send_beat(in_beat_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(b);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_powers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// written only once the core has nothing in flight
	task automatic write_modulus(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.modulus = v;
	endtask

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'(sb.modulus) + 32'($urandom_range(3)) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	// small exponents keep the run short; a few span all 63 bits
	function automatic in_beat_t rand_beat();
		in_beat_t b;
		int r;
		b.entry_00 = rand_entry();
		b.entry_01 = rand_entry();
		b.entry_10 = rand_entry();
		b.entry_11 = rand_entry();
		r = $urandom_range(999);
		if (r < 100) b.power = '0;
		else if (r < 850) b.power = 63'($urandom_range(1, 7));
		else if (r < 990) b.power = 63'($urandom_range(8, 255));
		else b.power = 63'({$urandom, $urandom});
		return b;
	endfunction

	task automatic random_phase(logic [31:0] m, int n, int s_idle, int r_stall);
		write_modulus(m);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		for (int i = 0; i < n; i++) send_beat(rand_beat());
		phases++;
	endtask

	function automatic in_beat_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d, logic [62:0] p);
		in_beat_t x;
		x.entry_00 = a;
		x.entry_01 = b;
		x.entry_10 = c;
		x.entry_11 = d;
		x.power = p;
		return x;
	endfunction

	initial begin
		#400_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset modulus: power zero, extremes, entries above modulus
		send_beat(mk(0, 0, 0, 0, 0));
		send_beat(mk('1, '1, '1, '1, 0));
		send_beat(mk('1, '1, '1, '1, 1));
		send_beat(mk(1, 1, 1, 0, 10));
		send_beat(mk(1000000007, 1000000008, 32'hffff_fffe, 5, 1));
		send_beat(mk(0, 0, 0, 0, 1));
		send_beat(mk('1, 0, 0, '1, 63'h7fff_ffff_ffff_ffff));
		send_beat(mk(2, 3, 5, 7, 63'h4000_0000_0000_0000));

		// modulus 1: identity for power zero stays unreduced, all else zero
		write_modulus(1);
		send_beat(mk(7, 8, 9, 10, 0));
		send_beat(mk(7, 8, 9, 10, 5));
		// largest modulus: sums close to the 64-bit edge
		write_modulus(32'hffff_ffff);
		send_beat(mk('1, 32'hffff_fffe, 32'hffff_fffe, '1, 3));
		send_beat(mk(32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffe, 63'h155));
		write_modulus(2);
		send_beat(mk(1, 1, 1, 0, 63'h7fff_ffff_ffff_ffff));

		// long receiver hold-off while the sender keeps offering
		drain();
		hold_req = 6000;
		repeat (2) @(posedge clk);
		for (int i = 0; i < 8; i++)
			send_beat(mk($urandom, $urandom, $urandom, $urandom, 1));

		random_phase(1000000007, 200, 0, 0);
		random_phase(32'hffff_ffff, 200, 86, 0);
		random_phase(1, 150, 0, 86);
		random_phase(2, 150, 37, 37);
		random_phase($urandom_range(32'hffff_ffff, 1), 200, 0, 0);
		random_phase(32'h8000_0000, 150, 86, 0);
		random_phase($urandom_range(65535, 3), 150, 0, 86);
		random_phase($urandom_range(32'hffff_ffff, 1), 200, 37, 37);

		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d matrices over %0d random phases, %0d results checked",
			sent, phases, sb.checked);
		$display("moduli from 1 to 2^32-1, exponents from zero to all 63 bits set");
		if (sb.errors == 0 && sb.pending_powers.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/mmp_pkg.sv
rtl/mmp_mulred.sv
rtl/mod_matrix_power_2x2_core.sv
verif/tb_mod_matrix_power_2x2_core.sv
